/* sv/sgs_pkg.sv */
// ----------------------------------------------------------------------------
// sgs_pkg
// Shared constants, command types and fixed-point helpers of the spectral
// gain smoother.
// ----------------------------------------------------------------------------
package sgs_pkg;

    localparam logic [15:0] Q_ONE       = 16'd32768;
    localparam logic [15:0] Q_HALF      = 16'd16384;
    localparam logic [15:0] TAP_SIDE    = 16'd655;
    localparam logic [15:0] TAP_MID     = 16'd31458;
    localparam logic [15:0] W_OLD       = 16'd9830;
    localparam logic [15:0] W_NEW       = 16'd22938;
    localparam logic [15:0] TAPER_STEP  = 16'd30802;
    localparam logic [15:0] TAPER_FLOOR = 16'd10;

    localparam int          CFG_ADDR_W  = 2;
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_GAIN = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_OFFSET   = 2'd1;

    typedef struct packed {
        logic load_in;
        logic load_top;
        logic do_freq;
        logic do_time;
        logic do_taper;
    } sgs_cmd_t;

    function automatic logic [15:0] sat_q17(input logic [16:0] v);
        logic [15:0] r;
        r = (v > 17'(Q_ONE)) ? Q_ONE : v[15:0];
        return r;
    endfunction

    function automatic logic [15:0] qmul_sat(input logic [15:0] a, input logic [15:0] b);
        logic [31:0] p;
        p = 32'(a) * 32'(b) + 32'(Q_HALF);
        return sat_q17(p[31:15]);
    endfunction

endpackage

/* sv/sgs_ctrl.sv */
// ----------------------------------------------------------------------------
// sgs_ctrl
// Sequencer of the smoother: bin counter, handshakes and the step commands
// that drive the datapath through one result at a time.
// ----------------------------------------------------------------------------
module sgs_ctrl #(
    parameter int HALF_BINS = 256,
    parameter int BIN_W     = $clog2(HALF_BINS)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    output sgs_pkg::sgs_cmd_t   cmd,
    output logic [BIN_W-1:0]    rd_addr,
    output logic [BIN_W-1:0]    bin
);
    import sgs_pkg::*;

    localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(HALF_BINS - 1);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_FREQ  = 5'b00010,
        ST_TIME  = 5'b00100,
        ST_TAPER = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    logic [BIN_W-1:0]  cnt_reg, cnt_next;
    logic [BIN_W-1:0]  bin_reg, bin_next;
    logic              second_reg, second_next;
    logic              s_acc, m_acc;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);
    assign s_acc   = s_valid && s_ready;
    assign m_acc   = m_valid && m_ready;
    assign bin     = bin_reg;

    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        bin_next    = bin_reg;
        second_next = second_reg;
        cmd         = '0;
        rd_addr     = (cnt_reg == '0) ? '0 : cnt_reg - 1'b1;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    cnt_next    = (cnt_reg == LAST_BIN) ? '0 : cnt_reg + 1'b1;
                    if (cnt_reg != '0) begin
                        bin_next    = cnt_reg - 1'b1;
                        second_next = (cnt_reg == LAST_BIN);
                        state_next  = ST_FREQ;
                    end
                end
            end
            ST_FREQ: begin
                cmd.do_freq = 1'b1;
                state_next  = ST_TIME;
            end
            ST_TIME: begin
                cmd.do_time = 1'b1;
                state_next  = ST_TAPER;
            end
            ST_TAPER: begin
                cmd.do_taper = 1'b1;
                state_next   = ST_OUT;
            end
            ST_OUT: begin
                rd_addr = LAST_BIN;
                if (m_ready) begin
                    if (second_reg) begin
                        cmd.load_top = 1'b1;
                        second_next  = 1'b0;
                        bin_next     = LAST_BIN;
                        state_next   = ST_FREQ;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            bin_reg    <= '0;
            second_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            bin_reg    <= bin_next;
            second_reg <= second_next;
        end
    end

    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input accepted while a result is pending");

    a_first_bin_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && cnt_reg == '0) |=> (state_reg == ST_IDLE))
        else $error("first bin of a frame started a result");

    a_top_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_acc && second_reg) |=> (state_reg == ST_FREQ && bin_reg == LAST_BIN))
        else $error("top bin result not started after the one before it");

    a_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && cnt_reg == LAST_BIN) |=> (cnt_reg == '0 && second_reg))
        else $error("bin counter did not wrap on the top bin");

endmodule

/* sv/sgs_datapath.sv */
// ----------------------------------------------------------------------------
// sgs_datapath
// Raw gain window, gain store, taper table and the frequency, time and
// taper arithmetic, with the configuration registers and result register.
// ----------------------------------------------------------------------------
module sgs_datapath #(
    parameter int HALF_BINS = 256,
    parameter int BIN_W     = $clog2(HALF_BINS)
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  sgs_pkg::sgs_cmd_t                  cmd,
    input  logic [BIN_W-1:0]                   rd_addr,
    input  logic [BIN_W-1:0]                   bin,
    input  logic                               cfg_wr_en,
    input  logic [sgs_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [15:0]                        cfg_wdata,
    input  logic [15:0]                        raw_gain,
    output logic [7:0]                         out_bin_index,
    output logic [15:0]                        out_gain,
    output logic                               out_last
);
    import sgs_pkg::*;

    localparam int CMP_W = (BIN_W > 8) ? BIN_W : 8;
    localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(HALF_BINS - 1);

    typedef logic [15:0] taper_rom_t [HALF_BINS];

    function automatic taper_rom_t taper_init();
        taper_rom_t t;
        for (int i = 0; i < HALF_BINS; i++) begin
            if (i < HALF_BINS / 2) begin
                t[i] = Q_ONE;
            end else if (i < (HALF_BINS * 3) / 4) begin
                t[i] = qmul_sat(t[i-1], TAPER_STEP);
            end else begin
                t[i] = TAPER_FLOOR;
            end
        end
        return t;
    endfunction

    localparam taper_rom_t TAPER_ROM = taper_init();

    logic [15:0] store_mem [HALF_BINS];

    logic [15:0] min_gain_reg;
    logic [7:0]  offset_reg;
    logic [15:0] prev_reg, prev_prev_reg;
    logic [15:0] left_reg, mid_reg, right_reg;
    logic [15:0] store_rd_reg, taper_rd_reg;
    logic        fresh_reg;
    logic        filled_reg;
    logic [15:0] f_reg, t_reg;
    logic [7:0]  res_bin_reg;
    logic [15:0] res_gain_reg;
    logic        res_last_reg;
    logic [15:0] raw_sat, store_eff, mul_a, g_val;
    logic [31:0] freq_acc, time_acc;
    logic [CMP_W-1:0] bin_ext, off_ext;
    logic        is_floor;

    assign raw_sat   = (raw_gain > Q_ONE) ? Q_ONE : raw_gain;
    assign store_eff = fresh_reg ? Q_ONE : store_rd_reg;
    assign bin_ext   = CMP_W'(bin);
    assign off_ext   = CMP_W'(offset_reg);
    assign is_floor  = (bin_ext < off_ext) || (bin == LAST_BIN);

    assign freq_acc = 32'(TAP_SIDE) * (32'(left_reg) + 32'(right_reg))
                    + 32'(TAP_MID) * 32'(mid_reg) + 32'(Q_HALF);
    assign time_acc = 32'(W_OLD) * 32'(store_eff) + 32'(W_NEW) * 32'(f_reg)
                    + 32'(Q_HALF);
    assign mul_a    = is_floor ? min_gain_reg : t_reg;
    assign g_val    = qmul_sat(mul_a, taper_rd_reg);

    assign out_bin_index = res_bin_reg;
    assign out_gain      = res_gain_reg;
    assign out_last      = res_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_gain_reg  <= 16'd2458;
            offset_reg    <= '0;
            prev_reg      <= '0;
            prev_prev_reg <= '0;
            filled_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    REG_MIN_GAIN: min_gain_reg <= (cfg_wdata > Q_ONE) ? Q_ONE : cfg_wdata;
                    REG_OFFSET:   offset_reg   <= cfg_wdata[7:0];
                    default: begin
                    end
                endcase
            end
            if (cmd.load_in) begin
                prev_prev_reg <= prev_reg;
                prev_reg      <= raw_sat;
            end
            if (cmd.do_taper && bin == LAST_BIN) begin
                filled_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            left_reg  <= prev_prev_reg;
            mid_reg   <= prev_reg;
            right_reg <= raw_sat;
        end else if (cmd.load_top) begin
            left_reg  <= mid_reg;
            mid_reg   <= right_reg;
            right_reg <= '0;
        end
        if (cmd.load_in || cmd.load_top) begin
            store_rd_reg <= store_mem[rd_addr];
            taper_rd_reg <= TAPER_ROM[rd_addr];
            fresh_reg    <= !filled_reg;
        end
        if (cmd.do_freq) begin
            f_reg <= (bin == '0) ? mid_reg : sat_q17(freq_acc[31:15]);
        end
        if (cmd.do_time) begin
            t_reg <= sat_q17(time_acc[31:15]);
        end
        if (cmd.do_taper) begin
            store_mem[bin] <= g_val;
            res_gain_reg   <= g_val;
            res_bin_reg    <= bin_ext[7:0];
            res_last_reg   <= (bin == LAST_BIN);
        end
    end

endmodule

/* sv/spectral_gain_smoother.sv */
// ----------------------------------------------------------------------------
// spectral_gain_smoother
// Per-bin suppression gain smoothing over frequency and time with a
// low-pass taper and a configurable floor for the lowest bins and the
// top bin.
// A result is valid once the beat of the bin after it is taken and the
// frequency, time and taper steps have run. A new bin is taken only when
// idle, set by the three-step arithmetic and the single result register;
// a frame's first bin starts no result and its top bin starts two.
// Reset: synchronous, active low; no clearing pass, the gain store reads
// as 1.0 until the first frame has written every bin.
module spectral_gain_smoother #(
    parameter int HALF_BINS = 256
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [sgs_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [15:0]                     cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [15:0]                     s_raw_gain,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [7:0]                      m_bin_index,
    output logic [15:0]                     m_smoothed_gain,
    output logic                            m_frame_last
);
    import sgs_pkg::*;

    localparam int BIN_W = $clog2(HALF_BINS);

    sgs_cmd_t          cmd;
    logic [BIN_W-1:0]  rd_addr;
    logic [BIN_W-1:0]  bin;

    sgs_ctrl #(
        .HALF_BINS (HALF_BINS),
        .BIN_W     (BIN_W)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .rd_addr (rd_addr),
        .bin     (bin)
    );

    sgs_datapath #(
        .HALF_BINS (HALF_BINS),
        .BIN_W     (BIN_W)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .rd_addr       (rd_addr),
        .bin           (bin),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .raw_gain      (s_raw_gain),
        .out_bin_index (m_bin_index),
        .out_gain      (m_smoothed_gain),
        .out_last      (m_frame_last)
    );

endmodule
